/* hdl/ckct_pkg.sv */
// Shared types and constants for the color key centroid tracker.
package ckct_pkg;

  localparam int unsigned DefMaxWidth   = 2048;
  localparam int unsigned DefMaxHeight  = 2048;
  localparam int unsigned DefFracBits   = 4;

  localparam int unsigned RefW    = 12;
  localparam int unsigned RadW    = 8;
  localparam int unsigned CountW  = 23;
  localparam int unsigned SumW    = 33;
  localparam int unsigned OutW    = 12;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 12;

  localparam logic [RadW-1:0] RadiusReset = 8'd10;
  localparam logic [OutW-1:0] MeanMax     = 12'd2047;
  localparam logic [OutW-1:0] NoMatch     = 12'hFFF;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BLUE_A  = 3'd0,
    REG_GREEN_A = 3'd1,
    REG_RED_A   = 3'd2,
    REG_BLUE_B  = 3'd3,
    REG_GREEN_B = 3'd4,
    REG_RED_B   = 3'd5,
    REG_RADIUS  = 3'd6
  } cfg_reg_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic pix_take;   // accumulate the pixel held in the input register
    logic div_start;  // latch the frame totals and start the divides
    logic div_step;   // one quotient bit for all four divides
  } dp_cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic frame_last;  // the held pixel closes its frame
  } dp_sts_t;

endpackage

/* hdl/ckct_ctrl.sv */
// Controller: input handshake, divide sequencing and output register control.
module ckct_ctrl
  import ckct_pkg::*;
#(
  parameter int unsigned QuotW = 34
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  output logic    m_tvalid,
  input  logic    m_tready,
  output logic    load_in,
  output logic    load_out,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  localparam int unsigned StepW = $clog2(QuotW + 1);

  typedef enum logic [1:0] {S_RUN, S_DIV, S_DONE} state_t;

  state_t           state;
  logic             held;
  logic [StepW-1:0] steps;

  // The pixel register empties every cycle while running; it is blocked while
  // a frame's divides run or their result waits for a free output register.
  assign s_tready = (state == S_RUN) && !(held && sts.frame_last);
  assign load_in  = s_tvalid && s_tready;

  assign cmd.pix_take  = held && (state == S_RUN);
  assign cmd.div_start = held && (state == S_RUN) && sts.frame_last;
  assign cmd.div_step  = (state == S_DIV);
  assign load_out      = (state == S_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_RUN;
      held     <= 1'b0;
      steps    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_RUN: begin
          held <= load_in;
          if (cmd.div_start) begin
            state <= S_DIV;
            steps <= StepW'(QuotW);
          end
        end
        S_DIV: begin
          steps <= steps - 1'b1;
          if (steps == StepW'(1)) state <= S_DONE;
        end
        S_DONE: begin
          if (load_out) state <= S_RUN;
        end
        default: state <= S_RUN;
      endcase
    end
  end

endmodule

/* hdl/ckct_dp.sv */
// Datapath: color match, position counters, accumulators and serial dividers.
module ckct_dp
  import ckct_pkg::*;
#(
  parameter int unsigned MAX_WIDTH     = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT    = DefMaxHeight,
  parameter int unsigned REF_FRAC_BITS = DefFracBits,
  parameter int unsigned QuotW         = 34
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDatW-1:0]  cfg_data,
  input  logic                load_in,
  input  logic [7:0]          in_blue,
  input  logic [7:0]          in_green,
  input  logic [7:0]          in_red,
  input  logic                in_line_end,
  input  logic                in_frame_end,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  input  logic                load_out,
  output logic [OutW-1:0]     centroid_x_a,
  output logic [OutW-1:0]     centroid_y_a,
  output logic [OutW-1:0]     centroid_x_b,
  output logic [OutW-1:0]     centroid_y_b,
  output logic [CountW-1:0]   hits_a,
  output logic [CountW-1:0]   hits_b
);

  localparam int unsigned ColW  = $clog2(MAX_WIDTH);
  localparam int unsigned RowW  = $clog2(MAX_HEIGHT);
  localparam int unsigned CompW = 8 + REF_FRAC_BITS;
  localparam int unsigned SqW   = 2 * CompW;
  localparam int unsigned DistW = SqW + 2;
  localparam int unsigned LimW  = RadW + REF_FRAC_BITS;
  localparam int unsigned RemW  = CountW + 1;

  logic [RefW-1:0] ref_a [3];
  logic [RefW-1:0] ref_b [3];
  logic [RadW-1:0] radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_a[0] <= '0; ref_a[1] <= '0; ref_a[2] <= '0;
      ref_b[0] <= '0; ref_b[1] <= '0; ref_b[2] <= '0;
      radius   <= RadiusReset;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLUE_A:  ref_a[0] <= cfg_data;
        REG_GREEN_A: ref_a[1] <= cfg_data;
        REG_RED_A:   ref_a[2] <= cfg_data;
        REG_BLUE_B:  ref_b[0] <= cfg_data;
        REG_GREEN_B: ref_b[1] <= cfg_data;
        REG_RED_B:   ref_b[2] <= cfg_data;
        REG_RADIUS:  radius   <= cfg_data[RadW-1:0];
        default: ;
      endcase
    end
  end

  // Input stage: pixel register plus squared distances to both colors.
  logic [7:0] pix [3];
  logic       line_end_q, frame_end_q;
  logic [SqW-1:0] sq_a [3];
  logic [SqW-1:0] sq_b [3];

  function automatic logic [SqW-1:0] sq_diff(input logic [7:0] p, input logic [RefW-1:0] r);
    logic [CompW:0] pw, rw, d;
    pw = {1'b0, p, {REF_FRAC_BITS{1'b0}}};
    rw = (CompW + 1)'(r);
    d  = (pw > rw) ? pw - rw : rw - pw;
    return SqW'(d * d);
  endfunction

  always_ff @(posedge clk) begin
    if (load_in) begin
      pix[0] <= in_blue; pix[1] <= in_green; pix[2] <= in_red;
      line_end_q  <= in_line_end;
      frame_end_q <= in_frame_end;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_a[i] = sq_diff(pix[i], ref_a[i]);
      sq_b[i] = sq_diff(pix[i], ref_b[i]);
    end
  end

  assign sts.frame_last = frame_end_q;

  logic [LimW-1:0]   lim;
  logic [2*LimW-1:0] lim_sq;
  logic [DistW-1:0]  dist_a, dist_b;
  logic              hit_a, hit_b;

  assign lim    = {radius, {REF_FRAC_BITS{1'b0}}};
  assign lim_sq = lim * lim;
  assign dist_a = DistW'(sq_a[0]) + DistW'(sq_a[1]) + DistW'(sq_a[2]);
  assign dist_b = DistW'(sq_b[0]) + DistW'(sq_b[1]) + DistW'(sq_b[2]);
  assign hit_a  = dist_a < DistW'(lim_sq);
  assign hit_b  = dist_b < DistW'(lim_sq);

  // Position and accumulators.
  logic [ColW-1:0]   col;
  logic [RowW-1:0]   row;
  logic [CountW-1:0] cnt_a, cnt_b;
  logic [SumW-1:0]   scol_a, srow_a, scol_b, srow_b;

  function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] s, input logic [SumW-1:0] v);
    logic [SumW:0] t;
    t = {1'b0, s} + {1'b0, v};
    return t[SumW] ? '1 : t[SumW-1:0];
  endfunction

  logic acc_a, acc_b;
  assign acc_a = hit_a && (cnt_a != '1);
  assign acc_b = hit_b && (cnt_b != '1);

  // Frame totals are captured for the divides the same cycle the sums clear.
  logic [CountW-1:0] fin_cnt_a, fin_cnt_b;
  logic [SumW-1:0]   fin_scol_a, fin_srow_a, fin_scol_b, fin_srow_b;

  always_comb begin
    fin_cnt_a  = cnt_a  + CountW'(acc_a);
    fin_cnt_b  = cnt_b  + CountW'(acc_b);
    fin_scol_a = acc_a ? sat_add(scol_a, SumW'(col)) : scol_a;
    fin_srow_a = acc_a ? sat_add(srow_a, SumW'(row)) : srow_a;
    fin_scol_b = acc_b ? sat_add(scol_b, SumW'(col)) : scol_b;
    fin_srow_b = acc_b ? sat_add(srow_b, SumW'(row)) : srow_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0; row <= '0;
      cnt_a <= '0; cnt_b <= '0;
      scol_a <= '0; srow_a <= '0; scol_b <= '0; srow_b <= '0;
    end else if (cmd.pix_take) begin
      if (frame_end_q) begin
        col <= '0; row <= '0;
        cnt_a <= '0; cnt_b <= '0;
        scol_a <= '0; srow_a <= '0; scol_b <= '0; srow_b <= '0;
      end else begin
        cnt_a <= fin_cnt_a; cnt_b <= fin_cnt_b;
        scol_a <= fin_scol_a; srow_a <= fin_srow_a;
        scol_b <= fin_scol_b; srow_b <= fin_srow_b;
        if (line_end_q) begin
          col <= '0;
          if (row != RowW'(MAX_HEIGHT - 1)) row <= row + 1'b1;
        end else if (col != ColW'(MAX_WIDTH - 1)) begin
          col <= col + 1'b1;
        end
      end
    end
  end

  // Four restoring dividers sharing one step command, one quotient bit a cycle.
  logic [CountW-1:0] dvs_a, dvs_b;
  logic [QuotW-1:0]  num [4];
  logic [RemW-1:0]   rem [4];
  logic [RemW-1:0]   rem_sh [4];
  logic [RemW-1:0]   dvs [4];

  assign dvs[0] = RemW'(dvs_a); assign dvs[1] = RemW'(dvs_a);
  assign dvs[2] = RemW'(dvs_b); assign dvs[3] = RemW'(dvs_b);

  always_comb begin
    for (int i = 0; i < 4; i++) rem_sh[i] = {rem[i][RemW-2:0], num[i][QuotW-1]};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvs_a  <= fin_cnt_a;
      dvs_b  <= fin_cnt_b;
      num[0] <= QuotW'(fin_scol_a);
      num[1] <= QuotW'(fin_srow_a);
      num[2] <= QuotW'(fin_scol_b);
      num[3] <= QuotW'(fin_srow_b);
      for (int i = 0; i < 4; i++) rem[i] <= '0;
    end else if (cmd.div_step) begin
      for (int i = 0; i < 4; i++) begin
        if (rem_sh[i] >= dvs[i]) begin
          rem[i] <= rem_sh[i] - dvs[i];
          num[i] <= {num[i][QuotW-2:0], 1'b1};
        end else begin
          rem[i] <= rem_sh[i];
          num[i] <= {num[i][QuotW-2:0], 1'b0};
        end
      end
    end
  end

  function automatic logic [OutW-1:0] clamp(input logic [QuotW-1:0] q);
    return (q > QuotW'(MeanMax)) ? MeanMax : q[OutW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (load_out) begin
      centroid_x_a <= (dvs_a == '0) ? NoMatch : clamp(num[0]);
      centroid_y_a <= (dvs_a == '0) ? NoMatch : clamp(num[1]);
      centroid_x_b <= (dvs_b == '0) ? NoMatch : clamp(num[2]);
      centroid_y_b <= (dvs_b == '0) ? NoMatch : clamp(num[3]);
      hits_a <= dvs_a;
      hits_b <= dvs_b;
    end
  end

endmodule

/* hdl/color_key_centroid_tracker_unit.sv */
// Top level of the color key centroid tracker.
//
//  Channel | Direction | Contents
//  s_axis  | in        | tdata: pix_blue[7:0], pix_green[15:8], pix_red[23:16];
//          |           | tuser: line_end[0], frame_end[1]
//  m_axis  | out       | tdata: centroid_x_a, centroid_y_a, centroid_x_b,
//          |           | centroid_y_b (12 bits each), hits_a, hits_b (23 each)
//  cfg     | in        | cfg_we, cfg_index[2:0], cfg_data[11:0]
//
// Ordinary pixels are taken one per cycle; a pixel register feeds the match
// and accumulate stage. A frame-end pixel is held in the pixel register, then
// four shared-step restoring divides run and the output register is loaded;
// only then is the next request taken. If the previous result still waits in
// the output register, the load and the input wait with it. Reset
// (synchronous, active high) clears position, sums and configuration
// registers; no clearing pass is needed.
module color_key_centroid_tracker_unit
  import ckct_pkg::*;
#(
  parameter int unsigned MAX_WIDTH     = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT    = DefMaxHeight,
  parameter int unsigned REF_FRAC_BITS = DefFracBits
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,  // pix_blue, pix_green, pix_red
  input  logic [1:0]          s_axis_tuser,  // line_end, frame_end
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [95:0]         m_axis_tdata,  // x_a, y_a, x_b, y_b, hits_a, hits_b, pad
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDatW-1:0]  cfg_data
);

  // Quotient width covers the saturated sums.
  localparam int unsigned QuotW = SumW + 1;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    load_in, load_out;
  logic [OutW-1:0]   cxa, cya, cxb, cyb;
  logic [CountW-1:0] ha, hb;

  ckct_ctrl #(.QuotW(QuotW)) u_ctrl (
    .clk, .rst,
    .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
    .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
    .load_in, .load_out, .cmd, .sts
  );

  ckct_dp #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
    .REF_FRAC_BITS(REF_FRAC_BITS), .QuotW(QuotW)
  ) u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .load_in,
    .in_blue(s_axis_tdata[7:0]), .in_green(s_axis_tdata[15:8]),
    .in_red(s_axis_tdata[23:16]),
    .in_line_end(s_axis_tuser[0]), .in_frame_end(s_axis_tuser[1]),
    .cmd, .sts, .load_out,
    .centroid_x_a(cxa), .centroid_y_a(cya), .centroid_x_b(cxb), .centroid_y_b(cyb),
    .hits_a(ha), .hits_b(hb)
  );

  assign m_axis_tdata = {2'b00, hb, ha, cyb, cxb, cya, cxa};

  // A request is never taken while a frame's divides are in flight.
  assert property (@(posedge clk) disable iff (rst) cmd.div_step |-> !s_axis_tready)
    else $error("input taken during divide");

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A new result becomes valid only after a load of the output register.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(load_out))
    else $error("result appeared without load");

endmodule

/* test/color_key_centroid_tracker_unit_tb.sv */
// Self-checking testbench for the color key centroid tracker: pixel streams in, centroids out.
module color_key_centroid_tracker_unit_tb;
  import ckct_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxCol = DefMaxWidth - 1;
  localparam int unsigned MaxRow = DefMaxHeight - 1;
  localparam longint unsigned CountMax = (64'd1 << CountW) - 1;
  localparam longint unsigned SumMax = (64'd1 << SumW) - 1;

  // One frame summary as it leaves the block.
  typedef struct packed {
    logic [22:0] hits_b;
    logic [22:0] hits_a;
    logic [11:0] y_b;
    logic [11:0] x_b;
    logic [11:0] y_a;
    logic [11:0] x_a;
  } centroid_t;

  // One row of the directed table; chk marks a hand-typed expectation.
  typedef struct {
    logic [7:0] b, g, r;
    logic le, fe;
    logic chk;
    centroid_t want;
  } pix_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // pix_blue[7:0], pix_green[15:8], pix_red[23:16]
  logic [1:0] s_axis_tuser = '0;    // line_end[0], frame_end[1]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;        // x_a, y_a, x_b, y_b, hits_a, hits_b, 2 pad bits
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDatW-1:0] cfg_data = '0;

  color_key_centroid_tracker_unit uut (.*);

  always #5 clk = ~clk;

  // Predictor state: the register file and the frame accumulators.
  logic [11:0] ref_color [2][3];
  logic [7:0] radius;
  int unsigned col_now, row_now;
  longint unsigned hits [2], col_sum [2], row_sum [2];

  centroid_t frames_due [$];
  int errors = 0;
  int frames_seen = 0;
  int pixels_sent = 0;
  logic drain_hold = 1'b0;   // forces a long receiver stall
  logic quiet = 1'b0;        // stretch with no idling on either side

  task automatic report(input string what, input logic [95:0] got, input logic [95:0] want);
    errors++;
    $display("MISMATCH frame %0d %s: got %0h want %0h", frames_seen, what, got, want);
  endtask

  function automatic logic [11:0] mean12(input longint unsigned s, input longint unsigned n);
    longint unsigned q;
    if (n == 0) return NoMatch;
    q = s / n;
    return (q > 2047) ? MeanMax : q[11:0];
  endfunction

  // Exact squared color distance against the radius, both widened to 8.4.
  function automatic logic near_color(input logic [7:0] b, g, r, input int k);
    longint signed db, dg, dr, lim;
    db = longint'({b, 4'b0}) - longint'(ref_color[k][0]);
    dg = longint'({g, 4'b0}) - longint'(ref_color[k][1]);
    dr = longint'({r, 4'b0}) - longint'(ref_color[k][2]);
    lim = longint'({radius, 4'b0});
    return (db * db + dg * dg + dr * dr) < lim * lim;
  endfunction

  // Advances the tracker model by one pixel; returns 1 when a summary is due.
  function automatic logic track_pixel(input logic [7:0] b, g, r, input logic le, fe,
                                       output centroid_t sum_out);
    for (int k = 0; k < 2; k++)
      if (near_color(b, g, r, k) && hits[k] < CountMax) begin
        hits[k]++;
        col_sum[k] = (col_sum[k] + col_now > SumMax) ? SumMax : col_sum[k] + col_now;
        row_sum[k] = (row_sum[k] + row_now > SumMax) ? SumMax : row_sum[k] + row_now;
      end
    sum_out = '0;
    if (fe) begin
      sum_out.x_a = mean12(col_sum[0], hits[0]);
      sum_out.y_a = mean12(row_sum[0], hits[0]);
      sum_out.x_b = mean12(col_sum[1], hits[1]);
      sum_out.y_b = mean12(row_sum[1], hits[1]);
      sum_out.hits_a = hits[0][22:0];
      sum_out.hits_b = hits[1][22:0];
      col_now = 0;
      row_now = 0;
      for (int k = 0; k < 2; k++) begin
        hits[k] = 0; col_sum[k] = 0; row_sum[k] = 0;
      end
      return 1'b1;
    end
    if (le) begin
      col_now = 0;
      if (row_now < MaxRow) row_now++;
    end else if (col_now < MaxCol) begin
      col_now++;
    end
    return 1'b0;
  endfunction

  // Writes one register of the block and mirrors it in the predictor.
  task automatic write_reg(input cfg_reg_t idx, input logic [11:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_RADIUS) radius = val[7:0];
    else ref_color[idx / 3][idx % 3] = val;
  endtask

  task automatic set_colors(input logic [11:0] ba, ga, ra, bb, gb, rb, input logic [7:0] rad);
    write_reg(REG_BLUE_A, ba);
    write_reg(REG_GREEN_A, ga);
    write_reg(REG_RED_A, ra);
    write_reg(REG_BLUE_B, bb);
    write_reg(REG_GREEN_B, gb);
    write_reg(REG_RED_B, rb);
    write_reg(REG_RADIUS, {4'b0, rad});
  endtask

  // Offers one pixel until the block takes it; the predictor sees it on acceptance.
  task automatic send_pixel(input logic [7:0] b, g, r, input logic le, fe,
                            input logic chk, input centroid_t want);
    centroid_t pred;
    while (!quiet && $urandom_range(99) < 26) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {r, g, b};
    s_axis_tuser <= {fe, le};
    do @(posedge clk); while (!s_axis_tready);
    pixels_sent++;
    if (track_pixel(b, g, r, le, fe, pred)) begin
      // A hand-typed row must agree with the predictor as well.
      if (chk && pred != want) report("table row expectation", 96'(pred), 96'(want));
      frames_due.push_back(pred);
    end
  endtask

  // Waits until every summary is in, then idles before config writes.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // Receiver: random stalls, plus a forced long hold during the pressure phase.
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= !drain_hold && (quiet || $urandom_range(99) >= 26);
  end

  // Output checker, field by field against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      centroid_t got, want;
      got = m_axis_tdata[93:0];
      if (frames_due.size() == 0) begin
        report("unexpected summary", m_axis_tdata, '0);
      end else begin
        want = frames_due.pop_front();
        if (got.x_a != want.x_a) report("centroid_x_a", got.x_a, want.x_a);
        if (got.y_a != want.y_a) report("centroid_y_a", got.y_a, want.y_a);
        if (got.x_b != want.x_b) report("centroid_x_b", got.x_b, want.x_b);
        if (got.y_b != want.y_b) report("centroid_y_b", got.y_b, want.y_b);
        if (got.hits_a != want.hits_a) report("hits_a", got.hits_a, want.hits_a);
        if (got.hits_b != want.hits_b) report("hits_b", got.hits_b, want.hits_b);
      end
      frames_seen++;
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("Timeout with %0d summaries outstanding", frames_due.size());
    $display("DONE: errors detected");
    $finish;
  end

  // Random frame whose rows mostly end in a line end; some pixels near the reference colors.
  task automatic random_frame(input int rows, input int cols);
    logic [7:0] b, g, r;
    int k;
    for (int y = 0; y < rows; y++)
      for (int x = 0; x < cols; x++) begin
        k = $urandom_range(3);
        if (k < 2) begin
          b = 8'((ref_color[k][0] >> 4) + $urandom_range(8) - 4);
          g = 8'((ref_color[k][1] >> 4) + $urandom_range(8) - 4);
          r = 8'((ref_color[k][2] >> 4) + $urandom_range(8) - 4);
        end else begin
          {b, g, r} = 24'($urandom);
        end
        send_pixel(b, g, r, x == cols - 1 && $urandom_range(15) != 0,
                   y == rows - 1 && x == cols - 1, 1'b0, '0);
      end
  endtask

  pix_row_t dir_rows [$];
  centroid_t none = '{default: '0, x_a: NoMatch, y_a: NoMatch, x_b: NoMatch, y_b: NoMatch};
  int frames_random = 0;

  initial begin
    centroid_t w;
    for (int k = 0; k < 2; k++) begin
      hits[k] = 0; col_sum[k] = 0; row_sum[k] = 0;
      for (int c = 0; c < 3; c++) ref_color[k][c] = '0;
    end
    radius = RadiusReset;
    col_now = 0;
    row_now = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After reset both references are black with radius 10: a black pixel hits both.
    w = '{default: '0};
    w.hits_a = 1; w.hits_b = 1;
    dir_rows.push_back('{8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 1'b1, w});
    // A white frame end alone matches nothing.
    dir_rows.push_back('{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 1'b1, none});
    // Distance 9 hits, distance exactly 10 does not.
    dir_rows.push_back('{8'd9, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, '0});
    dir_rows.push_back('{8'd0, 8'd10, 8'd0, 1'b1, 1'b0, 1'b0, '0});
    dir_rows.push_back('{8'd0, 8'd0, 8'd6, 1'b0, 1'b0, 1'b0, '0});
    dir_rows.push_back('{8'd200, 8'd1, 8'd1, 1'b1, 1'b0, 1'b0, '0});
    dir_rows.push_back('{8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b0, '0});
    foreach (dir_rows[i])
      send_pixel(dir_rows[i].b, dir_rows[i].g, dir_rows[i].r, dir_rows[i].le,
                 dir_rows[i].fe, dir_rows[i].chk, dir_rows[i].want);
    drain();

    // Extremes of the registers: full-scale references, zero and full radius.
    set_colors(12'hFF0, 12'hFF0, 12'hFF0, 12'h000, 12'hFFF, 12'h801, 8'd255);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, '0);
    send_pixel(8'h00, 8'hFF, 8'h80, 1'b1, 1'b0, 1'b0, '0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0, '0);
    drain();
    write_reg(REG_RADIUS, 12'd0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 1'b1, none);
    drain();

    // Saturation of the column counter: one long matching row past the width bound.
    set_colors(12'h000, 12'h000, 12'h000, 12'hFFF, 12'hFFF, 12'hFFF, 8'd255);
    for (int x = 0; x < DefMaxWidth + 40; x++)
      send_pixel(8'h00, 8'h00, 8'h00, 1'b0, x == DefMaxWidth + 39, 1'b0, '0);
    drain();

    // Pressure: hold the receiver while tiny frames keep arriving.
    quiet = 1'b1;
    drain_hold = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        drain_hold = 1'b0;
      end
      for (int f = 0; f < 6; f++) random_frame(1, 3);
    join
    quiet = 1'b0;
    drain();

    // Random part: several color settings, small frames with random shapes.
    while (pixels_sent < 800 + DefMaxWidth + 60 || frames_random < 60) begin
      if (frames_random % 15 == 0) begin
        drain();
        set_colors(12'($urandom_range(4080)), 12'($urandom_range(4080)),
                   12'($urandom_range(4080)), 12'($urandom_range(4080)),
                   12'($urandom_range(4080)), 12'($urandom_range(4080)),
                   8'($urandom_range(255)));
      end
      quiet = (frames_random >= 30 && frames_random < 38);
      random_frame($urandom_range(1, 4), $urandom_range(1, 6));
      frames_random++;
    end
    quiet = 1'b0;
    drain();

    $display("Covered %0d pixels in %0d frames over register extremes, threshold edges,",
             pixels_sent, frames_seen);
    $display("column saturation, a long output stall and random color settings.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
